FILE: rtl/core/isos_pkg.sv
// Package: shared types and constants for the incircle predicate.
package isos_pkg;

    // Sign forced for a fully degenerate set of points
    localparam logic POSITIVE = 1'b1;

    // Result fields of one item
    typedef struct packed {
        logic inside_res;
        logic tie_broken;
        logic degenerate;
    } isos_res_t;

endpackage

FILE: rtl/core/isos_if.sv
// Interfaces: valid/ready channels for point quadruples and results.
interface isos_in_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] qx;
    logic signed [COORD_BITS-1:0] qy;
    modport source (output valid, ax, ay, bx, by_coord, cx, cy, qx, qy, input ready);
    modport sink (input valid, ax, ay, bx, by_coord, cx, cy, qx, qy, output ready);
endinterface

interface isos_out_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic tie_broken;
    logic degenerate;
    modport source (output valid, inside_res, tie_broken, degenerate, input ready);
    modport sink (input valid, inside_res, tie_broken, degenerate, output ready);
endinterface

FILE: rtl/core/incircle_sos_predicate_top.sv
// Top level: pipelined exact incircle predicate with symbolic tie-break.
// Pipeline: each item passes through the stage registers in order, the last being the output register.
// Throughput: one item per cycle; a single global enable stalls all stages
// when the output register is full and not taken.
// Reset: rst_n asynchronously clears all stage valid bits; data is not reset.
module incircle_sos_predicate_top #(
    parameter int COORD_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    isos_in_if.sink    in_ch,
    isos_out_if.source out_ch
);
    import isos_pkg::*;

    localparam int DW = COORD_BITS + 1;   // coordinate difference
    localparam int PW = 2 * DW;           // product of two differences
    localparam int OW = PW + 1;           // orient / minor
    localparam int LW = PW + 1;           // lift (non-negative sum of squares)
    localparam int TW = LW + OW;          // one term of the determinant
    localparam int AW = TW + 2;           // sum of three terms

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    assign adv          = !v5_reg || out_ch.ready;
    assign in_ch.ready  = adv;

    // Stage 1: coordinate differences and ranking keys
    logic signed [DW-1:0] dx_reg [3];
    logic signed [DW-1:0] dy_reg [3];
    logic signed [COORD_BITS-1:0] px_reg [4];
    logic signed [COORD_BITS-1:0] py_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg[0] <= DW'(in_ch.ax) - DW'(in_ch.qx);
            dx_reg[1] <= DW'(in_ch.bx) - DW'(in_ch.qx);
            dx_reg[2] <= DW'(in_ch.cx) - DW'(in_ch.qx);
            dy_reg[0] <= DW'(in_ch.ay) - DW'(in_ch.qy);
            dy_reg[1] <= DW'(in_ch.by_coord) - DW'(in_ch.qy);
            dy_reg[2] <= DW'(in_ch.cy) - DW'(in_ch.qy);
            px_reg[0] <= in_ch.ax; py_reg[0] <= in_ch.ay;
            px_reg[1] <= in_ch.bx; py_reg[1] <= in_ch.by_coord;
            px_reg[2] <= in_ch.cx; py_reg[2] <= in_ch.cy;
            px_reg[3] <= in_ch.qx; py_reg[3] <= in_ch.qy;
        end
    end

    // Stage 2: squares and cross products of differences, and one-hot ranks
    // Orient cofactors in translated frame (q at origin):
    //   orient(b,c,q)=dxb*dyc-dyb*dxc, orient(a,c,q)=dxa*dyc-dya*dxc,
    //   orient(a,b,q)=dxa*dyb-dya*dxb, orient(a,b,c)=sum of the three minors.
    logic signed [PW-1:0] sq_reg [3][2];
    logic signed [PW-1:0] xy_reg [3][2];   // [i]: dx[m]*dy[n], dy[m]*dx[n]
    logic [3:0] rank_hi_reg [4];            // one-hot ranks, per point position

    // Ranking: position of point i = number of points before it in lex order
    function automatic logic lexgt(input logic signed [COORD_BITS-1:0] ux,
                                   input logic signed [COORD_BITS-1:0] uy,
                                   input logic signed [COORD_BITS-1:0] vx,
                                   input logic signed [COORD_BITS-1:0] vy);
        lexgt = (ux > vx) || (ux == vx && uy > vy);
    endfunction

    logic [1:0] pos_c [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pos_c[i] = '0;
            for (int j = 0; j < 4; j++)
            begin
                if (j < i && !lexgt(px_reg[j], py_reg[j], px_reg[i], py_reg[i]))
                    pos_c[i] = pos_c[i] + 2'd1;
                else if (j > i && lexgt(px_reg[i], py_reg[i], px_reg[j], py_reg[j]))
                    pos_c[i] = pos_c[i] + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i][0] <= PW'(dx_reg[i]) * PW'(dx_reg[i]);
                sq_reg[i][1] <= PW'(dy_reg[i]) * PW'(dy_reg[i]);
                xy_reg[i][0] <= PW'(dx_reg[(i+1)%3]) * PW'(dy_reg[(i+2)%3]);
                xy_reg[i][1] <= PW'(dy_reg[(i+1)%3]) * PW'(dx_reg[(i+2)%3]);
            end
            for (int i = 0; i < 4; i++)
                rank_hi_reg[i] <= 4'(1) << pos_c[i];
        end
    end

    // Stage 3: lifts and minors
    logic signed [LW-1:0] lift_reg [3];
    logic signed [OW-1:0] minor_reg [3];
    logic [3:0] rank3_reg [4];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lift_reg[i]  <= LW'(sq_reg[i][0]) + LW'(sq_reg[i][1]);
                minor_reg[i] <= OW'(xy_reg[i][0]) - OW'(xy_reg[i][1]);
            end
            rank3_reg <= rank_hi_reg;
        end
    end

    // Stage 4: determinant terms and cofactor signs
    // minor[0]=orient(b,c,q), minor[1]=-orient(a,c,q), minor[2]=orient(a,b,q)
    logic signed [TW-1:0] term_reg [3];
    logic [1:0] cs_reg [4];      // {nonzero, positive} per cofactor
    logic [3:0] rank4_reg [4];
    logic signed [OW+1:0] abc_c;
    assign abc_c = (OW+2)'(minor_reg[0]) + (OW+2)'(minor_reg[1]) + (OW+2)'(minor_reg[2]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                term_reg[i] <= TW'(lift_reg[i]) * TW'(minor_reg[i]);
                cs_reg[i]   <= {minor_reg[i] != '0, minor_reg[i] > 0};
            end
            // cofactor of q is -orient(a,b,c)
            cs_reg[3]  <= {abc_c != '0, abc_c < 0};
            rank4_reg  <= rank3_reg;
        end
    end

    // Stage 5: final sign, tie-break or degenerate result into output register
    logic signed [AW-1:0] acc_c;
    isos_res_t res_c;
    assign acc_c = AW'(term_reg[0]) + AW'(term_reg[1]) + AW'(term_reg[2]);

    always_comb
    begin
        logic found;
        found = 1'b0;
        res_c = '{inside_res: POSITIVE, tie_broken: 1'b0, degenerate: 1'b1};
        if (acc_c != '0)
            res_c = '{inside_res: !acc_c[AW-1], tie_broken: 1'b0, degenerate: 1'b0};
        else
        begin
            for (int k = 0; k < 4; k++)
                for (int i = 0; i < 4; i++)
                    if (rank4_reg[i][k] && cs_reg[i][1] && !found)
                    begin
                        found = 1'b1;
                        res_c = '{inside_res: cs_reg[i][0], tie_broken: 1'b1,
                                  degenerate: 1'b0};
                    end
        end
    end

    isos_res_t res_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_c;
    end

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign out_ch.valid      = v5_reg;
    assign out_ch.inside_res = res_reg.inside_res;
    assign out_ch.tie_broken = res_reg.tie_broken;
    assign out_ch.degenerate = res_reg.degenerate;
endmodule

FILE: rtl/core/isos_checker.sv
// Checker: port-level properties of the incircle predicate, bound to the top.
module isos_checker (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic inside_res,
    input logic tie_broken,
    input logic degenerate
);
    // Flags are exclusive; a degenerate result is positive
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(tie_broken && degenerate))
        else $error("tie and degenerate both set");
    a_degpos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> inside_res)
        else $error("degenerate result not positive");
    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({inside_res, tie_broken, degenerate}))
        else $error("stalled result changed");
    // Input is ready whenever the output side is free
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("not ready with empty output");
endmodule

bind incircle_sos_predicate_top isos_checker u_isos_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .inside_res (out_ch.inside_res),
    .tie_broken (out_ch.tie_broken),
    .degenerate (out_ch.degenerate)
);
